// ----- rtl/core/rth_pkg.sv -----
// Shared widths, types and register codes for the ray/triangle hit test core.
package rth_pkg;

    // Coordinate format
    localparam int CW    = 24;         // coordinate width
    localparam int FB    = 12;         // coordinate fraction bits
    localparam int EW    = CW + 1;     // edge / offset width
    localparam int XW    = 2 * EW + 1; // cross product component width
    localparam int LOW   = 26;         // low slice of a cross component
    localparam int HIW   = XW - LOW;   // high (signed) slice
    localparam int PLW   = EW + LOW + 2;
    localparam int PHW   = EW + HIW + 1;
    localparam int DW    = 80;         // dot product width, scale 2^-36
    localparam int RW    = 104;        // divider numerator / remainder width
    localparam int QB    = 23;         // quotient bits, one per divider stage
    localparam int UVF   = 16;         // barycentric fraction bits
    localparam int UVW   = UVF + 1;
    localparam int EPSW  = 48;
    localparam int TEPSW = 23;
    localparam int IDXW  = 3;
    localparam int PRE   = 8;          // pipeline stages ahead of the divider

    localparam logic [TEPSW-1:0] T_MAX = '1;

    typedef enum logic [IDXW-1:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_DET_EPS,
        REG_T_EPS
    } cfg_idx_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [XW-1:0] cross_t;
    typedef logic signed [DW-1:0] wide_t;
    typedef logic [RW-1:0]        rem_t;
    typedef logic [QB-1:0]        quo_t;

    typedef struct packed {
        logic miss;
        logic sat;
    } side_t;

endpackage

// ----- rtl/core/rth_if.sv -----
// Channel interfaces: triangle input, hit result and configuration write.
interface rth_tri_if;
    import rth_pkg::*;
    logic   valid;
    logic   ready;
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
    modport source (output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                    vertex1_z, vertex2_x, vertex2_y, vertex2_z, input ready);
    modport sink   (input valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
                    vertex1_z, vertex2_x, vertex2_y, vertex2_z, output ready);
endinterface

interface rth_res_if;
    import rth_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [TEPSW-1:0] hit_distance;
    logic [UVW-1:0]   bary_u;
    logic [UVW-1:0]   bary_v;
    modport source (output valid, hit, hit_distance, bary_u, bary_v, input ready);
    modport sink   (input valid, hit, hit_distance, bary_u, bary_v, output ready);
endinterface

interface rth_cfg_if;
    import rth_pkg::*;
    logic            valid;
    logic            ready;
    logic [IDXW-1:0] index;
    logic [EPSW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/rth_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, MSB first.
module rth_div (
    input  logic          clk,
    input  logic          en,
    input  rth_pkg::rem_t num,
    input  rth_pkg::rem_t den,
    output rth_pkg::quo_t quo,
    output logic          rem_nz
);
    import rth_pkg::*;

    rem_t rem_reg[QB];
    rem_t den_reg[QB-1];
    quo_t quo_reg[QB];

    rem_t rem_src[QB];
    rem_t den_src[QB];
    quo_t quo_src[QB];
    rem_t den_sh[QB];
    rem_t rem_next[QB];
    quo_t quo_next[QB];

    // stage i decides quotient bit QB-1-i
    always_comb
    begin
        rem_src[0] = num;
        den_src[0] = den;
        quo_src[0] = '0;
        for (int i = 1; i < QB; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            den_src[i] = den_reg[i-1];
            quo_src[i] = quo_reg[i-1];
        end
        for (int i = 0; i < QB; i++)
        begin
            den_sh[i] = den_src[i] << (QB - 1 - i);
            if (rem_src[i] >= den_sh[i])
            begin
                rem_next[i] = rem_src[i] - den_sh[i];
                quo_next[i] = quo_src[i] | (quo_t'(1) << (QB - 1 - i));
            end
            else
            begin
                rem_next[i] = rem_src[i];
                quo_next[i] = quo_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QB; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
            for (int i = 0; i < QB - 1; i++)
            begin
                den_reg[i] <= den_src[i];
            end
        end
    end

    assign quo    = quo_reg[QB-1];
    assign rem_nz = |rem_reg[QB-1];

endmodule

// ----- rtl/core/ray_triangle_hit_test_core.sv -----
// Top level: fixed-point Moller-Trumbore ray/triangle hit test pipeline.
//
//  channel   | dir | word
//  ----------+-----+------------------------------------------------
//  triangle  | in  | nine signed Q12.12 vertex coordinates
//  result    | out | hit, hit_distance (Q11.12), bary_u/bary_v (Q1.16)
//  cfg       | in  | register index + write data (ray, thresholds)
//
// One triangle per cycle while the result is not held; 8 arithmetic stages, 23 divider
// stages and one output register. The divider's one-bit-per-stage chain sets the depth.
// Reset clears the valid chain and loads the register defaults.
// A result held at the output freezes the whole pipeline; nothing is dropped.
module ray_triangle_hit_test_core (
    input logic      clk,
    input logic      rst_n,
    rth_tri_if.sink  triangle,
    rth_res_if.source result,
    rth_cfg_if.sink  cfg
);
    import rth_pkg::*;

    localparam int L_DET = 0;
    localparam int L_U   = 1;
    localparam int L_V   = 2;
    localparam int L_T   = 3;
    localparam int NV    = PRE + QB;

    // configuration registers
    coord_t           org_reg[3];
    coord_t           dir_reg[3];
    logic [EPSW-1:0]  deps_reg;
    logic [TEPSW-1:0] teps_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= coord_t'(4096);
            deps_reg   <= EPSW'(68719);
            teps_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_ORG_X:   org_reg[0] <= cfg.data[CW-1:0];
                REG_ORG_Y:   org_reg[1] <= cfg.data[CW-1:0];
                REG_ORG_Z:   org_reg[2] <= cfg.data[CW-1:0];
                REG_DIR_X:   dir_reg[0] <= cfg.data[CW-1:0];
                REG_DIR_Y:   dir_reg[1] <= cfg.data[CW-1:0];
                REG_DIR_Z:   dir_reg[2] <= cfg.data[CW-1:0];
                REG_DET_EPS: deps_reg   <= cfg.data;
                REG_T_EPS:   teps_reg   <= cfg.data[TEPSW-1:0];
                default:     deps_reg   <= deps_reg;
            endcase
        end
    end

    // pipeline advance: everything moves unless the output word is held
    logic out_vld_reg;
    logic adv;
    logic vld_reg[NV];

    assign adv            = !out_vld_reg || result.ready;
    assign triangle.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= triangle.valid;
            for (int i = 1; i < NV; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[NV-1];
        end
    end

    // input word unpacking
    coord_t v0[3];
    coord_t v1[3];
    coord_t v2[3];
    edge_t  dext[3];

    always_comb
    begin
        v0[0] = triangle.vertex0_x;
        v0[1] = triangle.vertex0_y;
        v0[2] = triangle.vertex0_z;
        v1[0] = triangle.vertex1_x;
        v1[1] = triangle.vertex1_y;
        v1[2] = triangle.vertex1_z;
        v2[0] = triangle.vertex2_x;
        v2[1] = triangle.vertex2_y;
        v2[2] = triangle.vertex2_z;
        for (int k = 0; k < 3; k++)
        begin
            dext[k] = EW'(dir_reg[k]);
        end
    end

    // stage 1: edges and origin offset
    edge_t e1_1_reg[3];
    edge_t e2_1_reg[3];
    edge_t s_1_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_1_reg[k] <= EW'(v1[k]) - EW'(v0[k]);
                e2_1_reg[k] <= EW'(v2[k]) - EW'(v0[k]);
                s_1_reg[k]  <= EW'(org_reg[k]) - EW'(v0[k]);
            end
        end
    end

    // stage 2: cross product terms, h = dir x e2, q = s x e1
    cross_t hp_a_reg[3];
    cross_t hp_b_reg[3];
    cross_t qp_a_reg[3];
    cross_t qp_b_reg[3];
    edge_t  e1_2_reg[3];
    edge_t  e2_2_reg[3];
    edge_t  s_2_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hp_a_reg[k] <= XW'(dext[(k+1)%3]) * XW'(e2_1_reg[(k+2)%3]);
                hp_b_reg[k] <= XW'(dext[(k+2)%3]) * XW'(e2_1_reg[(k+1)%3]);
                qp_a_reg[k] <= XW'(s_1_reg[(k+1)%3]) * XW'(e1_1_reg[(k+2)%3]);
                qp_b_reg[k] <= XW'(s_1_reg[(k+2)%3]) * XW'(e1_1_reg[(k+1)%3]);
                e1_2_reg[k] <= e1_1_reg[k];
                e2_2_reg[k] <= e2_1_reg[k];
                s_2_reg[k]  <= s_1_reg[k];
            end
        end
    end

    // stage 3: cross product differences
    cross_t h_reg[3];
    cross_t q_reg[3];
    edge_t  e1_3_reg[3];
    edge_t  e2_3_reg[3];
    edge_t  s_3_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_reg[k]    <= hp_a_reg[k] - hp_b_reg[k];
                q_reg[k]    <= qp_a_reg[k] - qp_b_reg[k];
                e1_3_reg[k] <= e1_2_reg[k];
                e2_3_reg[k] <= e2_2_reg[k];
                s_3_reg[k]  <= s_2_reg[k];
            end
        end
    end

    // stage 4: dot product partial products, cross operand split in two slices
    // lanes: det = e1.h, U = s.h, V = dir.q, T = e2.q
    edge_t  av[4][3];
    cross_t bv[4][3];
    logic signed [PLW-1:0] pl_reg[4][3];
    logic signed [PHW-1:0] ph_reg[4][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            av[L_DET][k] = e1_3_reg[k];
            bv[L_DET][k] = h_reg[k];
            av[L_U][k]   = s_3_reg[k];
            bv[L_U][k]   = h_reg[k];
            av[L_V][k]   = dext[k];
            bv[L_V][k]   = q_reg[k];
            av[L_T][k]   = e2_3_reg[k];
            bv[L_T][k]   = q_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pl_reg[j][k] <= PLW'(av[j][k])
                                    * PLW'($signed({1'b0, bv[j][k][LOW-1:0]}));
                    ph_reg[j][k] <= PHW'(av[j][k]) * PHW'($signed(bv[j][k][XW-1:LOW]));
                end
            end
        end
    end

    // stage 5: recombine slices
    wide_t cs_reg[4][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cs_reg[j][k] <= (DW'(ph_reg[j][k]) <<< LOW) + DW'(pl_reg[j][k]);
                end
            end
        end
    end

    // stage 6: dot sums
    wide_t dot_reg[4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                dot_reg[j] <= cs_reg[j][0] + cs_reg[j][1] + cs_reg[j][2];
            end
        end
    end

    // stage 7: negate all lanes when det is negative, making det nonnegative
    wide_t fl_reg[4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                fl_reg[j] <= dot_reg[L_DET][DW-1] ? -dot_reg[j] : dot_reg[j];
            end
        end
    end

    // stage 8: bound tests and divider operands
    wide_t          uv_sum;
    logic [DW-1:0]  det_u;
    side_t          side_next;
    rem_t           tnum_reg;
    rem_t           unum_reg;
    rem_t           vnum_reg;
    rem_t           den_reg;
    side_t          side_reg;

    always_comb
    begin
        uv_sum = fl_reg[L_U] + fl_reg[L_V];
        det_u  = fl_reg[L_DET];
        side_next.miss = (det_u == '0) || (det_u < DW'(deps_reg))
                      || fl_reg[L_U][DW-1] || (fl_reg[L_U] > fl_reg[L_DET])
                      || fl_reg[L_V][DW-1] || (uv_sum > fl_reg[L_DET])
                      || fl_reg[L_T][DW-1];
        side_next.sat  = RW'(fl_reg[L_T]) >= (RW'(det_u) << (QB - FB));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tnum_reg <= RW'(fl_reg[L_T]) << FB;
            unum_reg <= RW'(fl_reg[L_U]) << UVF;
            vnum_reg <= RW'(fl_reg[L_V]) << UVF;
            den_reg  <= RW'(det_u);
            side_reg <= side_next;
        end
    end

    // divider stages
    quo_t  tq;
    quo_t  uq;
    quo_t  vq;
    logic  t_rnz;
    logic  u_rnz;
    logic  v_rnz;
    side_t sb_reg[QB];

    rth_div u_div_t (.clk(clk), .en(adv), .num(tnum_reg), .den(den_reg),
                     .quo(tq), .rem_nz(t_rnz));
    rth_div u_div_u (.clk(clk), .en(adv), .num(unum_reg), .den(den_reg),
                     .quo(uq), .rem_nz(u_rnz));
    rth_div u_div_v (.clk(clk), .en(adv), .num(vnum_reg), .den(den_reg),
                     .quo(vq), .rem_nz(v_rnz));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= side_reg;
            for (int i = 1; i < QB; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // output register: t threshold test is exact via quotient and remainder
    logic             t_ok;
    logic             hit_next;
    logic             hit_reg;
    logic [TEPSW-1:0] dist_reg;
    logic [UVW-1:0]   u_reg;
    logic [UVW-1:0]   v_reg;

    always_comb
    begin
        t_ok = sb_reg[QB-1].sat || (tq > teps_reg)
            || ((tq == teps_reg) && t_rnz);
        hit_next = !sb_reg[QB-1].miss && t_ok;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_next;
            dist_reg <= !hit_next ? '0 : (sb_reg[QB-1].sat ? T_MAX : tq);
            u_reg    <= hit_next ? uq[UVW-1:0] : '0;
            v_reg    <= hit_next ? vq[UVW-1:0] : '0;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.hit          = hit_reg;
    assign result.hit_distance = dist_reg;
    assign result.bary_u       = u_reg;
    assign result.bary_v       = v_reg;

    // checks
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !hit_reg |-> dist_reg == '0 && u_reg == '0 && v_reg == '0)
        else $error("miss word carries nonzero fields");

    a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && hit_reg |-> ({1'b0, u_reg} + {1'b0, v_reg}) <= (UVW+1)'(65536))
        else $error("barycentric sum above one");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg[NV-1]) && $stable(hit_reg) && $stable(dist_reg))
        else $error("pipeline moved during stall");

    // u_rnz and v_rnz are only needed for truncation; fold into a sanity check
    a_u_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && hit_reg && u_reg == (UVW)'(65536) |-> v_reg == '0)
        else $error("u at one with nonzero v");

    logic unused_rnz;
    assign unused_rnz = u_rnz ^ v_rnz;

    a_rnz_known: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> !$isunknown(unused_rnz) || !vld_reg[NV-1])
        else $error("divider remainder flag unknown");

endmodule
